FILE: src/lzot_pkg.sv
// ----------------------------------------------------------------------------
// Layer z-order table package
// Shared widths, request codes and defaults for the layer depth-order table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzot_pkg;

  // Default table size
  localparam int unsigned NumSlotsDef = 32;

  // Field widths
  localparam int unsigned ReqW    = 3;
  localparam int unsigned SlotInW = 5;
  localparam int unsigned IdW     = 32;
  localparam int unsigned ZW      = 32;

  // Request codes
  localparam logic [ReqW-1:0] REQ_LOAD = 3'd0;
  localparam logic [ReqW-1:0] REQ_SET  = 3'd1;
  localparam logic [ReqW-1:0] REQ_GET  = 3'd2;
  localparam logic [ReqW-1:0] REQ_NORM = 3'd3;
  localparam logic [ReqW-1:0] REQ_FIND = 3'd4;

  // Status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // Depth returned by a get that finds no layer (-1)
  localparam logic [ZW-1:0] Z_NOT_FOUND = '1;

endpackage

FILE: src/layer_z_order_table.sv
// ----------------------------------------------------------------------------
// Layer z-order table
// Compositor layer slots with id lookup, depth find and stable rank normalize.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request: load a slot, set
//   or get a depth by layer id, find a slot by depth, or normalize. Each
//   request gives exactly one result on the output channel
//   (out_valid_o/out_ready_i). in_ready_o is high only while the sequencer
//   is idle; one request is in work at a time.
//   Set, get and find scan the slots and stop at the first hit; normalize
//   ranks each active slot against all slots, then writes the ranks back.
//   Each scan uses the single shared 32-bit comparator, fed one slot per
//   cycle from the id and depth memories through their read port.
//   Reset clears all active marks; ids and depths are not cleared.
//   A result waiting for a stalled receiver is held in the output register;
//   the next request is still accepted and the sequencer waits for the
//   output register only when its own result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layer_z_order_table #(
  parameter int unsigned NUM_SLOTS = lzot_pkg::NumSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lzot_pkg::ReqW-1:0]    req_type_i,
  input  logic [lzot_pkg::SlotInW-1:0] slot_i,
  input  logic [lzot_pkg::IdW-1:0]     layer_id_i,
  input  logic                         active_i,
  input  logic signed [lzot_pkg::ZW-1:0] z_value_i,
  input  logic [lzot_pkg::ZW-1:0]      position_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic signed [lzot_pkg::ZW-1:0] z_out_o,
  output logic [lzot_pkg::SlotInW-1:0] slot_out_o,
  output logic [lzot_pkg::IdW-1:0]     id_out_o
);

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = SLOT_W + 1;
  localparam int unsigned EXT_W  = SLOT_W + lzot_pkg::SlotInW;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(NUM_SLOTS);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DISP    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_NORM_I  = 3'd3;
  localparam logic [2:0] S_NORM_DI = 3'd4;
  localparam logic [2:0] S_NORM_J  = 3'd5;
  localparam logic [2:0] S_COPY    = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0] state_q, state_d;

  // Latched request
  logic [lzot_pkg::ReqW-1:0]    req_q;
  logic [lzot_pkg::SlotInW-1:0] slot_q;
  logic [lzot_pkg::IdW-1:0]     id_q;
  logic                         act_q;
  logic [lzot_pkg::ZW-1:0]      z_q;
  logic [lzot_pkg::ZW-1:0]      pos_q;

  // Scan pipeline
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0] pcnt_q, pcnt_d;
  logic              pv_q, pv_d;
  logic              issue;

  // Normalize state
  logic [SLOT_W-1:0]       i_q, i_d;
  logic [lzot_pkg::ZW-1:0] di_q, di_d;
  logic [SLOT_W-1:0]       rank_q, rank_d;
  logic [SLOT_W-1:0]       rank_nxt;
  logic                    norm_inc;

  // Active marks
  logic [NUM_SLOTS-1:0] valid_q, valid_d;

  // Pending result
  logic                         res_status_q, res_status_d;
  logic [lzot_pkg::ZW-1:0]      res_z_q, res_z_d;
  logic [lzot_pkg::SlotInW-1:0] res_slot_q, res_slot_d;
  logic [lzot_pkg::IdW-1:0]     res_id_q, res_id_d;

  // Output register
  logic                         out_valid_q;
  logic                         out_status_q;
  logic [lzot_pkg::ZW-1:0]      out_z_q;
  logic [lzot_pkg::SlotInW-1:0] out_slot_q;
  logic [lzot_pkg::IdW-1:0]     out_id_q;
  logic                         resp_fire;

  // Memory ports
  logic [SLOT_W-1:0]       rd_addr;
  logic                    id_we;
  logic                    dep_we;
  logic [SLOT_W-1:0]       dep_waddr;
  logic [lzot_pkg::ZW-1:0] dep_wdata;
  logic                    rank_we;
  logic [lzot_pkg::IdW-1:0] id_rdata;
  logic [lzot_pkg::ZW-1:0]  dep_rdata;
  logic [SLOT_W-1:0]        rank_rdata;

  // Load address
  logic [EXT_W-1:0]  slot_ext;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_ok;

  // Shared comparator
  logic                    id_mode;
  logic [lzot_pkg::ZW-1:0] cmp_a, cmp_b;
  logic                    cmp_eq, cmp_lt;

  assign slot_ext = EXT_W'(slot_q);
  assign slot_idx = slot_ext[SLOT_W-1:0];
  assign slot_ok  = slot_ext < EXT_W'(NUM_SLOTS);

  assign id_mode = (req_q == lzot_pkg::REQ_SET) || (req_q == lzot_pkg::REQ_GET);
  assign cmp_a   = id_mode ? id_rdata : dep_rdata;
  assign cmp_b   = id_mode ? id_q : ((req_q == lzot_pkg::REQ_FIND) ? pos_q : di_q);
  assign cmp_eq  = cmp_a == cmp_b;
  assign cmp_lt  = $signed(cmp_a) < $signed(cmp_b);

  // Rank step: slot j counts when it is active and ordered before slot i
  assign norm_inc = valid_q[pcnt_q] && (cmp_lt || (cmp_eq && (pcnt_q < i_q)));
  assign rank_nxt = rank_q + SLOT_W'(norm_inc);

  assign issue     = cnt_q < CNT_END;
  assign in_ready_o = state_q == S_IDLE;
  assign resp_fire = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pcnt_d       = pcnt_q;
    pv_d         = 1'b0;
    i_d          = i_q;
    di_d         = di_q;
    rank_d       = rank_q;
    valid_d      = valid_q;
    res_status_d = res_status_q;
    res_z_d      = res_z_q;
    res_slot_d   = res_slot_q;
    res_id_d     = res_id_q;
    rd_addr      = cnt_q[SLOT_W-1:0];
    id_we        = 1'b0;
    dep_we       = 1'b0;
    dep_waddr    = slot_idx;
    dep_wdata    = z_q;
    rank_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        res_status_d = lzot_pkg::STATUS_OK;
        res_z_d      = '0;
        res_slot_d   = '0;
        res_id_d     = '0;
        cnt_d        = '0;
        case (req_q)
          lzot_pkg::REQ_LOAD: begin
            if (slot_ok) begin
              valid_d[slot_idx] = act_q;
              id_we             = 1'b1;
              dep_we            = 1'b1;
            end
            state_d = S_RESP;
          end
          lzot_pkg::REQ_SET, lzot_pkg::REQ_GET, lzot_pkg::REQ_FIND: begin
            state_d = S_SCAN;
          end
          lzot_pkg::REQ_NORM: begin
            i_d     = '0;
            state_d = S_NORM_I;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Id or depth scan, stops at the lowest matching active slot
      S_SCAN: begin
        if (issue) begin
          pv_d   = 1'b1;
          pcnt_d = cnt_q[SLOT_W-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pv_q) begin
          if (valid_q[pcnt_q] && cmp_eq) begin
            case (req_q)
              lzot_pkg::REQ_SET: begin
                dep_we    = 1'b1;
                dep_waddr = pcnt_q;
              end
              lzot_pkg::REQ_GET: begin
                res_z_d = dep_rdata;
              end
              default: begin
                res_slot_d = lzot_pkg::SlotInW'(pcnt_q);
                res_id_d   = id_rdata;
              end
            endcase
            state_d = S_RESP;
          end else if (pcnt_q == LAST_IDX) begin
            res_status_d = lzot_pkg::STATUS_NOT_FOUND;
            if (req_q == lzot_pkg::REQ_GET) begin
              res_z_d = lzot_pkg::Z_NOT_FOUND;
            end
            state_d = S_RESP;
          end
        end
      end

      // Outer loop: fetch depth of slot i, skip inactive slots
      S_NORM_I: begin
        rd_addr = i_q;
        if (valid_q[i_q]) begin
          state_d = S_NORM_DI;
        end else if (i_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = S_COPY;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      S_NORM_DI: begin
        di_d    = dep_rdata;
        cnt_d   = '0;
        rank_d  = '0;
        state_d = S_NORM_J;
      end

      // Inner loop: count slots ordered before slot i
      S_NORM_J: begin
        if (issue) begin
          pv_d   = 1'b1;
          pcnt_d = cnt_q[SLOT_W-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pv_q) begin
          rank_d = rank_nxt;
          if (pcnt_q == LAST_IDX) begin
            rank_we = 1'b1;
            if (i_q == LAST_IDX) begin
              cnt_d   = '0;
              state_d = S_COPY;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = S_NORM_I;
            end
          end
        end
      end

      // Write ranks back into the depth store for active slots
      S_COPY: begin
        if (issue) begin
          pv_d   = 1'b1;
          pcnt_d = cnt_q[SLOT_W-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pv_q) begin
          if (valid_q[pcnt_q]) begin
            dep_we    = 1'b1;
            dep_waddr = pcnt_q;
            dep_wdata = lzot_pkg::ZW'(rank_rdata);
          end
          if (pcnt_q == LAST_IDX) begin
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (resp_fire) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      i_q     <= i_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pcnt_q       <= pcnt_d;
    di_q         <= di_d;
    rank_q       <= rank_d;
    res_status_q <= res_status_d;
    res_z_q      <= res_z_d;
    res_slot_q   <= res_slot_d;
    res_id_q     <= res_id_d;
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= req_type_i;
      slot_q <= slot_i;
      id_q   <= layer_id_i;
      act_q  <= active_i;
      z_q    <= z_value_i;
      pos_q  <= position_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      out_status_q <= res_status_q;
      out_z_q      <= res_z_q;
      out_slot_q   <= res_slot_q;
      out_id_q     <= res_id_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign z_out_o     = $signed(out_z_q);
  assign slot_out_o  = out_slot_q;
  assign id_out_o    = out_id_q;

  // Layer id store
  lzot_ram #(
    .WIDTH (lzot_pkg::IdW),
    .DEPTH (NUM_SLOTS)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (slot_idx),
    .wdata_i (id_q),
    .raddr_i (rd_addr),
    .rdata_o (id_rdata)
  );

  // Depth store
  lzot_ram #(
    .WIDTH (lzot_pkg::ZW),
    .DEPTH (NUM_SLOTS)
  ) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dep_rdata)
  );

  // Rank scratch store for normalize
  lzot_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (i_q),
    .wdata_i (rank_nxt),
    .raddr_i (rd_addr),
    .rdata_o (rank_rdata)
  );

`ifndef ASSERT_OFF
  // One request at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one in work");

  // Depth store is written only on dispatch, scan hit or rank copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_we |-> (state_q == S_DISP || state_q == S_SCAN || state_q == S_COPY))
    else $error("depth store written in unexpected state");

  // A result appears only from the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_RESP)
    else $error("result raised outside response state");
`endif

endmodule

FILE: src/lzot_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/layer_z_order_table_tb.sv
// ----------------------------------------------------------------------------
// Layer z-order table testbench
// Drives load, set, get, find, normalize and unknown requests through the
// valid/ready request channel and checks every result, in order, against
// fixed directed values or a local model of the slot table. A short directed
// table (reset state, extreme depths and ids, not-found cases, duplicate ids,
// ties) comes first, then random traffic built around a small pool of ids and
// depths so that lookups hit and normalize sees ties. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layer_z_order_table_tb;

  localparam int unsigned NUM_SLOTS    = lzot_pkg::NumSlotsDef;
  localparam int unsigned RAND_ITEMS   = 560;
  localparam int unsigned CHUNK_ITEMS  = 40;
  localparam int unsigned MAX_IDLE     = 19;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned NUM_DIRECTED = 25;

  // Request codes the block does not decode
  localparam logic [lzot_pkg::ReqW-1:0] REQ_UNKNOWN_LO  = 3'd5;
  localparam logic [lzot_pkg::ReqW-1:0] REQ_UNKNOWN_MID = 3'd6;
  localparam logic [lzot_pkg::ReqW-1:0] REQ_UNKNOWN_HI  = 3'd7;

  typedef struct packed {
    logic [lzot_pkg::ReqW-1:0]    kind;
    logic [lzot_pkg::SlotInW-1:0] slot;
    logic [lzot_pkg::IdW-1:0]     id;
    logic                         act;
    logic [lzot_pkg::ZW-1:0]      z;
    logic [lzot_pkg::ZW-1:0]      pos;
  } request_t;

  typedef struct packed {
    logic                         status;
    logic [lzot_pkg::ZW-1:0]      z;
    logic [lzot_pkg::SlotInW-1:0] slot;
    logic [lzot_pkg::IdW-1:0]     id;
  } result_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    result_t  want;
  } stim_row_t;

  localparam result_t RES_CLEAR = '{lzot_pkg::STATUS_OK, 32'd0, 5'd0, 32'd0};

  // Directed rows; rows with typed = 0 are checked against the table model
  localparam stim_row_t DIR_ROWS [NUM_DIRECTED] = '{
    // empty table after reset
    '{'{lzot_pkg::REQ_GET, 5'd0, 32'd5, 1'b0, 32'd0, 32'd0}, 1'b1,
      '{lzot_pkg::STATUS_NOT_FOUND, lzot_pkg::Z_NOT_FOUND, 5'd0, 32'd0}},
    '{'{lzot_pkg::REQ_FIND, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b1,
      '{lzot_pkg::STATUS_NOT_FOUND, 32'd0, 5'd0, 32'd0}},
    '{'{lzot_pkg::REQ_NORM, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b1, RES_CLEAR},
    // unknown requests change nothing
    '{'{REQ_UNKNOWN_LO, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b1, RES_CLEAR},
    '{'{REQ_UNKNOWN_MID, 5'd7, 32'd3, 1'b1, 32'd1, 32'd1}, 1'b1, RES_CLEAR},
    '{'{REQ_UNKNOWN_HI, 5'd31, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b1, RES_CLEAR},
    // extreme ids and depths in the end slots
    '{'{lzot_pkg::REQ_LOAD, 5'd0, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'd0},
      1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_LOAD, 5'd31, 32'd0, 1'b1, 32'h8000_0000, 32'd0},
      1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_GET, 5'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0}, 1'b1,
      '{lzot_pkg::STATUS_OK, 32'h7FFF_FFFF, 5'd0, 32'd0}},
    '{'{lzot_pkg::REQ_GET, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b1,
      '{lzot_pkg::STATUS_OK, 32'h8000_0000, 5'd0, 32'd0}},
    '{'{lzot_pkg::REQ_FIND, 5'd0, 32'd0, 1'b0, 32'd0, 32'h8000_0000}, 1'b1,
      '{lzot_pkg::STATUS_OK, 32'd0, 5'd31, 32'd0}},
    '{'{lzot_pkg::REQ_FIND, 5'd0, 32'd0, 1'b0, 32'd0, 32'h7FFF_FFFF}, 1'b1,
      '{lzot_pkg::STATUS_OK, 32'd0, 5'd0, 32'hFFFF_FFFF}},
    '{'{lzot_pkg::REQ_SET, 5'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd0},
      1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_FIND, 5'd0, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF}, 1'b1,
      '{lzot_pkg::STATUS_OK, 32'd0, 5'd31, 32'd0}},
    // retire slot 31, then a lone active layer normalizes to depth 0
    '{'{lzot_pkg::REQ_LOAD, 5'd31, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_SET, 5'd0, 32'd0, 1'b0, 32'd1, 32'd0}, 1'b1,
      '{lzot_pkg::STATUS_NOT_FOUND, 32'd0, 5'd0, 32'd0}},
    '{'{lzot_pkg::REQ_NORM, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_GET, 5'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0},
      1'b1, RES_CLEAR},
    // duplicate id (lowest slot wins) and tied depths
    '{'{lzot_pkg::REQ_LOAD, 5'd5, 32'd7, 1'b1, 32'd0, 32'd0}, 1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_LOAD, 5'd3, 32'd9, 1'b1, 32'd0, 32'd0}, 1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_LOAD, 5'd10, 32'd7, 1'b1, 32'hFFFF_FFFB, 32'd0},
      1'b1, RES_CLEAR},
    '{'{lzot_pkg::REQ_NORM, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1'b0, RES_CLEAR},
    '{'{lzot_pkg::REQ_GET, 5'd0, 32'd7, 1'b0, 32'd0, 32'd0}, 1'b0, RES_CLEAR},
    '{'{lzot_pkg::REQ_FIND, 5'd0, 32'd0, 1'b0, 32'd0, 32'd2}, 1'b0, RES_CLEAR},
    '{'{lzot_pkg::REQ_SET, 5'd0, 32'd9, 1'b0, 32'h8000_0000, 32'd0},
      1'b0, RES_CLEAR}
  };

  logic                         clk;
  logic                         rst_n      = 1'b0;
  logic                         req_valid  = 1'b0;
  logic                         req_ready;
  logic [lzot_pkg::ReqW-1:0]    req_kind   = lzot_pkg::REQ_LOAD;
  logic [lzot_pkg::SlotInW-1:0] req_slot   = '0;
  logic [lzot_pkg::IdW-1:0]     req_id     = '0;
  logic                         req_act    = 1'b0;
  logic [lzot_pkg::ZW-1:0]      req_z      = '0;
  logic [lzot_pkg::ZW-1:0]      req_pos    = '0;
  logic                         res_valid;
  logic                         res_ready  = 1'b0;
  logic                         res_status;
  logic [lzot_pkg::ZW-1:0]      res_z;
  logic [lzot_pkg::SlotInW-1:0] res_slot;
  logic [lzot_pkg::IdW-1:0]     res_id;

  // Model of the slot table
  logic                         lay_on [NUM_SLOTS];
  logic [lzot_pkg::IdW-1:0]     lay_id [NUM_SLOTS];
  logic [lzot_pkg::ZW-1:0]      lay_z  [NUM_SLOTS];

  result_t                      pending_results [$];
  logic [lzot_pkg::IdW-1:0]     id_pool [8];
  int unsigned                  ops_seen [8];
  int unsigned                  n_checked  = 0;
  int unsigned                  n_errors   = 0;
  logic                         tx_idle_on = 1'b1;
  logic                         rx_idle_on = 1'b1;

  layer_z_order_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .req_type_i (req_kind),
    .slot_i     (req_slot),
    .layer_id_i (req_id),
    .active_i   (req_act),
    .z_value_i  (req_z),
    .position_i (req_pos),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .status_o   (res_status),
    .z_out_o    (res_z),
    .slot_out_o (res_slot),
    .id_out_o   (res_id)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the table model and return the result it yields
  function automatic result_t apply_to_table(request_t rq);
    result_t     r;
    int          hit;
    int unsigned rank;
    logic [lzot_pkg::ZW-1:0] ranked [NUM_SLOTS];
    r   = RES_CLEAR;
    hit = -1;
    case (rq.kind)
      lzot_pkg::REQ_LOAD: begin
        if (rq.slot < NUM_SLOTS) begin
          lay_on[rq.slot] = rq.act;
          lay_id[rq.slot] = rq.id;
          lay_z[rq.slot]  = rq.z;
        end
      end
      lzot_pkg::REQ_SET, lzot_pkg::REQ_GET: begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (hit < 0 && lay_on[k] && lay_id[k] == rq.id) hit = k;
        end
        if (hit < 0) begin
          r.status = lzot_pkg::STATUS_NOT_FOUND;
          if (rq.kind == lzot_pkg::REQ_GET) r.z = lzot_pkg::Z_NOT_FOUND;
        end else if (rq.kind == lzot_pkg::REQ_SET) begin
          lay_z[hit] = rq.z;
        end else begin
          r.z = lay_z[hit];
        end
      end
      lzot_pkg::REQ_NORM: begin
        // stable rank: signed depth, ties to the lower slot
        for (int i = 0; i < NUM_SLOTS; i++) begin
          rank = 0;
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (j != i && lay_on[j] &&
                ($signed(lay_z[j]) < $signed(lay_z[i]) ||
                 (lay_z[j] == lay_z[i] && j < i))) rank++;
          end
          ranked[i] = lay_on[i] ? lzot_pkg::ZW'(rank) : lay_z[i];
        end
        for (int i = 0; i < NUM_SLOTS; i++) lay_z[i] = ranked[i];
      end
      lzot_pkg::REQ_FIND: begin
        r.status = lzot_pkg::STATUS_NOT_FOUND;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (hit < 0 && lay_on[k] && lay_z[k] == rq.pos) hit = k;
        end
        if (hit >= 0) begin
          r.status = lzot_pkg::STATUS_OK;
          r.slot   = lzot_pkg::SlotInW'(hit);
          r.id     = lay_id[hit];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [lzot_pkg::IdW-1:0] draw_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Small depths give ties and find hits; the rest spans the full range
  function automatic logic [lzot_pkg::ZW-1:0] draw_depth();
    logic [lzot_pkg::ZW-1:0] d;
    case ($urandom_range(0, 3))
      0, 1:    d = lzot_pkg::ZW'($urandom_range(0, 8)) - lzot_pkg::ZW'(3);
      2:       d = $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       d = 32'h8000_0000;
          1:       d = 32'h7FFF_FFFF;
          2:       d = 32'hFFFF_FFFF;
          default: d = 32'd0;
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic request_t draw_request();
    request_t    rq;
    int unsigned pick;
    int unsigned k;
    rq.slot = lzot_pkg::SlotInW'($urandom_range(0, NUM_SLOTS - 1));
    rq.id   = draw_id();
    rq.act  = ($urandom_range(0, 4) != 0);
    rq.z    = draw_depth();
    rq.pos  = $urandom();
    pick    = $urandom_range(0, 99);
    if (pick < 35) begin
      rq.kind = lzot_pkg::REQ_LOAD;
    end else if (pick < 48) begin
      rq.kind = lzot_pkg::REQ_SET;
    end else if (pick < 66) begin
      rq.kind = lzot_pkg::REQ_GET;
    end else if (pick < 84) begin
      rq.kind = lzot_pkg::REQ_FIND;
      k = $urandom_range(0, NUM_SLOTS - 1);
      case ($urandom_range(0, 4))
        0, 1, 2: rq.pos = lay_on[k] ? lay_z[k] : lzot_pkg::ZW'(k);
        3:       rq.pos = lzot_pkg::ZW'($urandom_range(0, NUM_SLOTS - 1));
        default: ;
      endcase
    end else if (pick < 94) begin
      rq.kind = lzot_pkg::REQ_NORM;
    end else begin
      rq.kind = REQ_UNKNOWN_LO + lzot_pkg::ReqW'($urandom_range(0, 2));
    end
    return rq;
  endfunction

  // Present one request, wait for acceptance, then log its expected result
  task automatic send_request(request_t rq, logic typed, result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_kind  <= rq.kind;
    req_slot  <= rq.slot;
    req_id    <= rq.id;
    req_act   <= rq.act;
    req_z     <= rq.z;
    req_pos   <= rq.pos;
    do @(posedge clk); while (!req_ready);
    predicted = apply_to_table(rq);
    pending_results.push_back(typed ? want : predicted);
    ops_seen[rq.kind]++;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, in-order compare
  initial begin
    int unsigned stall;
    result_t     want;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending (status %0d z %h slot %0d id %h)",
                 $time, res_status, res_z, res_slot, res_id);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (res_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d got %0d",
                   $time, want.status, res_status);
          n_errors++;
        end
        if (res_z !== want.z) begin
          $display("%0t: z_out mismatch, expected %h got %h", $time, want.z, res_z);
          n_errors++;
        end
        if (res_slot !== want.slot) begin
          $display("%0t: slot_out mismatch, expected %0d got %0d",
                   $time, want.slot, res_slot);
          n_errors++;
        end
        if (res_id !== want.id) begin
          $display("%0t: id_out mismatch, expected %h got %h", $time, want.id, res_id);
          n_errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    request_t rq;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      lay_on[i] = 1'b0;
      lay_id[i] = '0;
      lay_z[i]  = '0;
    end
    for (int i = 0; i < 8; i++) ops_seen[i] = 0;
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = $urandom();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_request(DIR_ROWS[r].rq, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // hold off until the directed results are all back
    req_valid <= 1'b0;
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % CHUNK_ITEMS == 0) begin
        // cycle through idling modes: both, none, sender only, receiver only
        case ((n / CHUNK_ITEMS) % 4)
          0: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
          1: begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
          2: begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
          default: begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
        endcase
        if (n == RAND_ITEMS / 2) begin
          req_valid <= 1'b0;
          drain_results();
        end
      end
      rq = draw_request();
      send_request(rq, 1'b0, RES_CLEAR);
    end
    req_valid <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (load %0d set %0d get %0d norm %0d find %0d other %0d)",
             NUM_DIRECTED + RAND_ITEMS, ops_seen[lzot_pkg::REQ_LOAD],
             ops_seen[lzot_pkg::REQ_SET], ops_seen[lzot_pkg::REQ_GET],
             ops_seen[lzot_pkg::REQ_NORM], ops_seen[lzot_pkg::REQ_FIND],
             ops_seen[REQ_UNKNOWN_LO] + ops_seen[REQ_UNKNOWN_MID] +
             ops_seen[REQ_UNKNOWN_HI]);
    $display("%0d results compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: layer_z_order_table.f
src/lzot_pkg.sv
src/lzot_ram.sv
src/layer_z_order_table.sv
tb/layer_z_order_table_tb.sv
